// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the log approximation block.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_PROP(lbl, !(cond), msg)

`endif

// ===== rtl/core/fnla_pkg.sv =====
// Types, constants and arithmetic helpers of the fixed-point natural log block.
// Used by fast_natural_log_approx; depends on nothing else.
package fnla_pkg;

  // Q.60 working word, split into a 31-bit low half and a signed high half.
  localparam int unsigned QW = 62;
  localparam int unsigned PW = 2 * QW + 2;
  localparam int unsigned LOG_W = 35;

  typedef logic signed [QW-1:0] q60_t;

  // Partial products of one Q.60 by Q.60 multiplication.
  typedef struct packed {
    logic signed [61:0] hh;
    logic signed [62:0] hl;
    logic signed [62:0] lh;
    logic signed [63:0] ll;
  } pp_t;

  localparam logic [63:0] BIAS_PATTERN = 64'h3FE5555555555555;
  localparam logic [10:0] EXP_ONE      = 11'h3FF;

  // Polynomial coefficients, exact in Q.60.
  localparam q60_t C5_Q60 = 62'h1d8c0f0 << 33;
  localparam q60_t C4_Q60 = -(62'h11de8da << 34);
  localparam q60_t C3_Q60 = 62'h153ca34 << 34;
  localparam q60_t C2_Q60 = -(62'h1fee25a << 34);

  // ln2 with 25 fraction bits.
  localparam logic signed [25:0] LN2_Q25 = 26'sh162e430;

  localparam logic [LOG_W-1:0] LOG_MAX = 35'h3FFFFFFFF;
  localparam logic [LOG_W-1:0] LOG_MIN = 35'h400000000;

  function automatic pp_t mul_pp(input q60_t a, input q60_t b);
    logic signed [31:0] al;
    logic signed [31:0] bl;
    logic signed [30:0] ah;
    logic signed [30:0] bh;
    pp_t pp;
    al = {1'b0, a[30:0]};
    bl = {1'b0, b[30:0]};
    ah = a[QW-1:31];
    bh = b[QW-1:31];
    pp.hh = ah * bh;
    pp.hl = ah * bl;
    pp.lh = al * bh;
    pp.ll = al * bl;
    return pp;
  endfunction

  // Product scaled by 2^-60, rounded to nearest with ties away from zero, plus
  // a Q.60 addend. The addend enters above the rounding point, so it is exact.
  function automatic q60_t q60_round(input pp_t pp, input logic neg, input q60_t addend);
    logic signed [PW-1:0] acc;
    acc = (PW'(pp.hh) <<< 62) + (PW'(pp.hl) <<< 31) + (PW'(pp.lh) <<< 31)
        + PW'(pp.ll) + (PW'(addend) <<< 60) + (PW'(1) << 59) - PW'(neg);
    return acc[QW+59:60];
  endfunction

endpackage

// ===== rtl/core/fast_natural_log_approx.sv =====
// Throughput: one item per cycle while the skid buffer is empty; eight register
// stages (decode, three multiply and round pairs, final sum) plus an output
// register with a one-item skid buffer.
// Reset (rst_ni, asynchronous, active low) clears all valid bits; payload is not reset.
// Depends on fnla_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fast_natural_log_approx
  import fnla_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] value_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [34:0] log_value, [39:35] zero
  output logic        m_axis_tuser_o    // [0] domain_error
);

  localparam int unsigned SH = 52 - FRAC_BITS;
  localparam int unsigned TW = 66;
  localparam int unsigned RW = TW + 1;

  logic        en;
  logic        in_acc;
  logic [8:1]  v_q;

  // Stage 1: decode.
  logic [63:0]        diff;
  logic signed [11:0] k_d;
  logic [10:0]        expf;
  logic signed [53:0] fm;
  q60_t               f_d;
  logic               err_d;
  logic signed [11:0] k1_q;
  q60_t               f1_q;
  logic               err1_q;

  // Stage 2: first products.
  pp_t                ppff2_q, ppc5_2_q, ppc3_2_q;
  logic signed [37:0] kl2_q;
  q60_t               f2_q;
  logic               err2_q;

  // Stage 3: s, r1, t.
  q60_t               s3_q, r1_3_q, t3_q, f3_q;
  logic signed [37:0] kl3_q;
  logic               err3_q;

  // Stage 4: r1 * s.
  pp_t                pp4_q;
  logic               neg4_q;
  q60_t               s4_q, t4_q, f4_q;
  logic signed [37:0] kl4_q;
  logic               err4_q;

  // Stage 5: r2.
  q60_t               r2_5_q, s5_q, f5_q;
  logic signed [37:0] kl5_q;
  logic               err5_q;

  // Stage 6: r2 * s.
  pp_t                pp6_q;
  logic               neg6_q;
  q60_t               f6_q;
  logic signed [37:0] kl6_q;
  logic               err6_q;

  // Stage 7: r3.
  q60_t               r3_7_q;
  logic signed [37:0] kl7_q;
  logic               err7_q;

  // Stage 8: total in Q.52.
  logic signed [TW-1:0] tot8_q;
  logic                 err8_q;

  // Output side.
  logic signed [RW-1:0] rsum;
  logic signed [RW-1:0] rsh;
  logic                 ovf;
  logic [LOG_W-1:0]     new_log;
  logic                 new_v;
  logic                 out_v_q, out_v_d;
  logic                 skid_v_q, skid_v_d;
  logic                 out_load, skid_load;
  logic [LOG_W-1:0]     out_log_q, skid_log_q;
  logic                 out_err_q, skid_err_q;

  assign en              = ~skid_v_q;
  assign s_axis_tready_o = en;
  assign in_acc          = s_axis_tvalid_i & en;

  always_comb begin
    diff  = s_axis_tdata_i - BIAS_PATTERN;
    k_d   = diff[63:52];
    expf  = s_axis_tdata_i[62:52] - k_d[10:0];
    err_d = s_axis_tdata_i[63] | (&s_axis_tdata_i[62:52]) | (s_axis_tdata_i == '0);
    // Below one the reduced value has the exponent of one half.
    fm    = $signed({2'b00, s_axis_tdata_i[51:0]}) - $signed(54'h10000000000000);
    if (expf == EXP_ONE) begin
      f_d = {2'b00, s_axis_tdata_i[51:0], 8'h00};
    end else begin
      f_d = q60_t'(fm) <<< 7;
    end
  end

  // Round the Q.52 total to FRAC_BITS with ties upward and saturate; errors give 0.
  always_comb begin
    rsum = RW'(tot8_q) + (RW'(1) << (SH - 1));
    rsh  = rsum >>> SH;
    ovf  = ~((&rsh[RW-1:LOG_W-1]) | ~(|rsh[RW-1:LOG_W-1]));
    if (err8_q) begin
      new_log = '0;
    end else if (ovf) begin
      new_log = rsh[RW-1] ? LOG_MIN : LOG_MAX;
    end else begin
      new_log = rsh[LOG_W-1:0];
    end
  end

  always_comb begin
    new_v     = v_q[8] & en;
    out_load  = 1'b0;
    skid_load = 1'b0;
    if (!out_v_q || m_axis_tready_i) begin
      out_v_d  = skid_v_q | new_v;
      out_load = 1'b1;
      skid_v_d = 1'b0;
    end else begin
      out_v_d   = 1'b1;
      skid_v_d  = skid_v_q | new_v;
      skid_load = new_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[7:1], in_acc};
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q     <= k_d;
      f1_q     <= f_d;
      err1_q   <= err_d;

      ppff2_q  <= mul_pp(f1_q, f1_q);
      ppc5_2_q <= mul_pp(C5_Q60, f1_q);
      ppc3_2_q <= mul_pp(C3_Q60, f1_q);
      kl2_q    <= k1_q * LN2_Q25;
      f2_q     <= f1_q;
      err2_q   <= err1_q;

      s3_q     <= q60_round(ppff2_q, 1'b0, '0);
      r1_3_q   <= q60_round(ppc5_2_q, C5_Q60[QW-1] ^ f2_q[QW-1], C4_Q60);
      t3_q     <= q60_round(ppc3_2_q, C3_Q60[QW-1] ^ f2_q[QW-1], C2_Q60);
      f3_q     <= f2_q;
      kl3_q    <= kl2_q;
      err3_q   <= err2_q;

      pp4_q    <= mul_pp(r1_3_q, s3_q);
      neg4_q   <= r1_3_q[QW-1] ^ s3_q[QW-1];
      s4_q     <= s3_q;
      t4_q     <= t3_q;
      f4_q     <= f3_q;
      kl4_q    <= kl3_q;
      err4_q   <= err3_q;

      r2_5_q   <= q60_round(pp4_q, neg4_q, t4_q);
      s5_q     <= s4_q;
      f5_q     <= f4_q;
      kl5_q    <= kl4_q;
      err5_q   <= err4_q;

      pp6_q    <= mul_pp(r2_5_q, s5_q);
      neg6_q   <= r2_5_q[QW-1] ^ s5_q[QW-1];
      f6_q     <= f5_q;
      kl6_q    <= kl5_q;
      err6_q   <= err5_q;

      r3_7_q   <= q60_round(pp6_q, neg6_q, f6_q);
      kl7_q    <= kl6_q;
      err7_q   <= err6_q;

      // k*ln2 is exact in Q.52; the polynomial is floored from Q.60 to Q.52.
      tot8_q   <= (TW'(kl7_q) <<< 27) + TW'(r3_7_q >>> 8);
      err8_q   <= err7_q;
    end
    if (out_load) begin
      out_log_q <= skid_v_q ? skid_log_q : new_log;
      out_err_q <= skid_v_q ? skid_err_q : err8_q;
    end
    if (skid_load) begin
      skid_log_q <= new_log;
      skid_err_q <= err8_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'b00000, out_log_q};
  assign m_axis_tuser_o  = out_err_q;

  `ASSERT_NEVER(a_skid_without_out, skid_v_q && !out_v_q, "skid full behind empty output")
  `ASSERT_PROP(a_err_gives_zero, out_v_q && out_err_q |-> out_log_q == '0, "nonzero flagged log")
  `ASSERT_PROP(a_pipe_frozen, !en |=> $stable(v_q), "pipeline moved while the skid was full")
  `ASSERT_PROP(a_zero_err, in_acc && s_axis_tdata_i == '0 |=> v_q[1] && err1_q, "zero unflagged")

endmodule
